[rtl/assert_macros.svh]
// assertion helpers for the checker in ibb_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/ibb_pkg.sv]
package ibb_pkg;

   localparam int HP_W = 16;
   localparam logic [HP_W-1:0] HALF_PERIOD_RESET = 16'd250;
   localparam logic [HP_W-1:0] HALF_PERIOD_MIN = 16'd1;

   localparam logic [1:0] FUNC_START = 2'd0;
   localparam logic [1:0] FUNC_STOP  = 2'd1;
   localparam logic [1:0] FUNC_WRITE = 2'd2;
   localparam logic [1:0] FUNC_READ  = 2'd3;

   // bit counter marks
   localparam logic [3:0] BIT_ACK  = 4'd8;
   localparam logic [3:0] BIT_TAIL = 4'd9;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] wr_data;
      logic       give_ack;
      logic [7:0] sda_samples;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       hold;
      logic [7:0] rd_data;
      logic       acked;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic is_scl;
      logic level;
      logic hold;
      logic last;
      logic adv;
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SEND,
      ST_WAIT
   } st_type;

endpackage

[rtl/ibb_timer.sv]
module ibb_timer (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [ibb_pkg::HP_W-1:0] half_period,
   output logic                     done
);
   import ibb_pkg::*;

   logic            busy_ff, busy_in;
   logic [HP_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = half_period;
      end else if (busy_ff) begin
         if (cnt_ff == HALF_PERIOD_MIN) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - HALF_PERIOD_MIN;
         end
      end
   end

   assign done = busy_ff && (cnt_ff == HALF_PERIOD_MIN);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
   end

endmodule

[rtl/i2c_bit_bang_master.sv]
// first phase word: a taken command goes to ST_LOAD, which registers it into rsp_ff
// each phase word: ST_LOAD, then the handoff in ST_SEND, then ST_WAIT on the timer if it holds
// a write command runs through 27 phases; rsp_stall can hold the handoff in ST_SEND
// the half-period counter in ibb_timer sets the pace; one command is in flight at a time
// reset: synchronous, lines released high, half_period back to 250, no word pending
module i2c_bit_bang_master (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  ibb_pkg::req_type         req_word,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output ibb_pkg::rsp_type         rsp_word,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [ibb_pkg::HP_W-1:0] csr_data
);
   import ibb_pkg::*;

   st_type          st_ff, st_in;
   logic [1:0]      func_ff, func_in;
   logic [7:0]      wsh_ff, wsh_in;
   logic            ack_ff, ack_in;
   logic [7:0]      smp_ff, smp_in;
   logic [7:0]      rd_ff, rd_in;
   logic [3:0]      bit_ff, bit_in;
   logic [1:0]      sub_ff, sub_in;
   logic            scl_ff, scl_in;
   logic            sda_ff, sda_in;
   logic [HP_W-1:0] hp_ff, hp_in;
   rsp_type         rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;

   phase_type ph;
   logic      take;
   logic      load;
   logic      sent;
   logic      tmr_start;
   logic      tmr_done;

   ibb_timer u_timer (
      .clock       (clock),
      .reset       (reset),
      .start       (tmr_start),
      .half_period (hp_ff),
      .done        (tmr_done)
   );

   // phase decode from command and position
   always_comb begin
      ph = '0;
      ph.hold = 1'b1;
      case (func_ff)
         FUNC_START: begin
            ph.is_scl = sub_ff[0];
            ph.level  = ~sub_ff[1];
            ph.last   = (sub_ff == 2'd3);
         end
         FUNC_STOP: begin
            ph.is_scl = sub_ff[0];
            ph.level  = (sub_ff != 2'd0);
            ph.last   = (sub_ff == 2'd2);
         end
         FUNC_WRITE: begin
            ph.is_scl = (sub_ff != 2'd0);
            ph.level  = (sub_ff == 2'd0) ? ((bit_ff == BIT_ACK) ? 1'b1 : wsh_ff[7])
                                         : (sub_ff == 2'd1);
            ph.adv    = (sub_ff == 2'd2);
            ph.last   = (bit_ff == BIT_ACK) && (sub_ff == 2'd2);
         end
         FUNC_READ: begin
            if (bit_ff == 4'd0) begin
               ph.level = 1'b1;
               ph.hold  = 1'b0;
               ph.adv   = 1'b1;
            end else if (bit_ff == BIT_TAIL) begin
               ph.is_scl = (sub_ff == 2'd1) || (sub_ff == 2'd2);
               case (sub_ff)
                  2'd0:    ph.level = ~ack_ff;
                  2'd1:    ph.level = 1'b1;
                  2'd2:    ph.level = 1'b0;
                  default: ph.level = 1'b1;
               endcase
               ph.hold = (sub_ff != 2'd3);
               ph.last = (sub_ff == 2'd3);
            end else begin
               ph.is_scl = 1'b1;
               ph.level  = ~sub_ff[0];
               ph.adv    = sub_ff[0];
            end
         end
         default: ph = '0;
      endcase
   end

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: begin
            if (req_valid) st_in = ST_LOAD;
         end
         ST_LOAD: st_in = ST_SEND;
         ST_SEND: begin
            if (!rsp_stall) begin
               if (rsp_ff.hold)      st_in = ST_WAIT;
               else if (rsp_ff.last) st_in = ST_IDLE;
               else                  st_in = ST_LOAD;
            end
         end
         ST_WAIT: begin
            if (tmr_done) st_in = rsp_ff.last ? ST_IDLE : ST_LOAD;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // outputs and strobes
   always_comb begin
      req_stall = (st_ff != ST_IDLE);
      rsp_valid = rsp_valid_ff;
      rsp_word  = rsp_ff;
      csr_ready = 1'b1;
      take      = (st_ff == ST_IDLE) && req_valid;
      load      = (st_ff == ST_LOAD);
      sent      = (st_ff == ST_SEND) && !rsp_stall;
      tmr_start = sent && rsp_ff.hold;
   end

   // datapath
   always_comb begin
      func_in      = func_ff;
      wsh_in       = wsh_ff;
      ack_in       = ack_ff;
      smp_in       = smp_ff;
      rd_in        = rd_ff;
      bit_in       = bit_ff;
      sub_in       = sub_ff;
      scl_in       = scl_ff;
      sda_in       = sda_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      hp_in        = hp_ff;

      if (csr_valid) begin
         hp_in = (csr_data == '0) ? HALF_PERIOD_MIN : csr_data;
      end

      if (take) begin
         func_in = req_word.func;
         wsh_in  = req_word.wr_data;
         ack_in  = req_word.give_ack;
         smp_in  = req_word.sda_samples;
         bit_in  = 4'd0;
         sub_in  = 2'd0;
      end

      if (load) begin
         if (ph.is_scl) scl_in = ph.level;
         else           sda_in = ph.level;
         rsp_in.scl_level = ph.is_scl ? ph.level : scl_ff;
         rsp_in.sda_level = ph.is_scl ? sda_ff : ph.level;
         rsp_in.hold      = ph.hold;
         rsp_in.last      = ph.last;
         rsp_in.rd_data   = ((func_ff == FUNC_READ) && ph.last) ? rd_ff : 8'd0;
         rsp_in.acked     = (func_ff == FUNC_WRITE) && ph.last && !smp_ff[0];
         rsp_valid_in     = 1'b1;
         if (ph.adv) begin
            bit_in = bit_ff + 4'd1;
            sub_in = 2'd0;
         end else begin
            sub_in = sub_ff + 2'd1;
         end
         // one data bit per scl cycle through the shifters
         if ((func_ff == FUNC_WRITE) && (sub_ff == 2'd0) && (bit_ff != BIT_ACK)) begin
            wsh_in = {wsh_ff[6:0], 1'b0};
         end
         if ((func_ff == FUNC_READ) && (sub_ff == 2'd0) && (bit_ff != 4'd0)
             && (bit_ff != BIT_TAIL)) begin
            rd_in  = {rd_ff[6:0], smp_ff[7]};
            smp_in = {smp_ff[6:0], 1'b0};
         end
      end

      if (sent) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         hp_ff        <= HALF_PERIOD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in;
         hp_ff        <= hp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff <= func_in;
      wsh_ff  <= wsh_in;
      ack_ff  <= ack_in;
      smp_ff  <= smp_in;
      rd_ff   <= rd_in;
      bit_ff  <= bit_in;
      sub_ff  <= sub_in;
      rsp_ff  <= rsp_in;
   end

endmodule

[rtl/ibb_checker.sv]
`include "assert_macros.svh"

module ibb_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input ibb_pkg::rsp_type rsp_word
);
   import ibb_pkg::*;

   // stalled phase word holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word), "rsp word changed while stalled")

   // no new command while a phase word is pending
   `ASSERT_ALWAYS(a_one_cmd, clock, reset, rsp_valid |-> req_stall, "command taken with phase word pending")

   // first phase follows a taken command
   `ASSERT_ALWAYS(a_first_phase, clock, reset, (req_valid && !req_stall) |-> ##2 rsp_valid, "no phase word after command")

   // result fields only on the final phase
   `ASSERT_ALWAYS(a_tail_fields, clock, reset, (rsp_valid && !rsp_word.last) |-> (rsp_word.rd_data == 8'd0 && !rsp_word.acked), "result fields set before last phase")

endmodule

bind i2c_bit_bang_master ibb_checker u_ibb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);
